>>> hdl/tsfb_pkg.sv
// ----------------------------------------------------------------------------
// tsfb_pkg
// Types, frame layout constants and CRC byte-update functions shared by the
// time-set frame builder.
// ----------------------------------------------------------------------------
package tsfb_pkg;

	localparam int unsigned FRAME_LEN = 27;
	localparam int unsigned POS_W     = $clog2(FRAME_LEN);

	localparam logic [7:0] HDR_BYTE   = 8'h15;
	localparam logic [7:0] MARK_BYTE  = 8'h80;
	localparam logic [7:0] FIXED_BYTE = 8'h05;

	localparam logic [15:0] CRC16_INIT = 16'hFFFF;
	localparam logic [15:0] CRC16_POLY = 16'hA001;  // reflected form of 0x8005
	localparam logic [7:0]  CRC8_INIT  = 8'h00;
	localparam logic [7:0]  CRC8_POLY  = 8'h01;

	// Frame byte positions
	localparam logic [POS_W-1:0] POS_HDR      = POS_W'(0);
	localparam logic [POS_W-1:0] POS_INV0     = POS_W'(1);
	localparam logic [POS_W-1:0] POS_INV1     = POS_W'(2);
	localparam logic [POS_W-1:0] POS_INV2     = POS_W'(3);
	localparam logic [POS_W-1:0] POS_INV3     = POS_W'(4);
	localparam logic [POS_W-1:0] POS_CTL0     = POS_W'(5);
	localparam logic [POS_W-1:0] POS_CTL1     = POS_W'(6);
	localparam logic [POS_W-1:0] POS_CTL2     = POS_W'(7);
	localparam logic [POS_W-1:0] POS_CTL3     = POS_W'(8);
	localparam logic [POS_W-1:0] POS_MARK     = POS_W'(9);
	localparam logic [POS_W-1:0] POS_OPT0     = POS_W'(10);
	localparam logic [POS_W-1:0] POS_OPT1     = POS_W'(11);
	localparam logic [POS_W-1:0] POS_TIME3    = POS_W'(12);
	localparam logic [POS_W-1:0] POS_TIME2    = POS_W'(13);
	localparam logic [POS_W-1:0] POS_TIME1    = POS_W'(14);
	localparam logic [POS_W-1:0] POS_TIME0    = POS_W'(15);
	localparam logic [POS_W-1:0] POS_FIXED    = POS_W'(19);
	localparam logic [POS_W-1:0] POS_C16_LAST = POS_W'(23);
	localparam logic [POS_W-1:0] POS_C16_HI   = POS_W'(24);
	localparam logic [POS_W-1:0] POS_C16_LO   = POS_W'(25);
	localparam logic [POS_W-1:0] POS_C8       = POS_W'(FRAME_LEN - 1);

	typedef struct packed {
		logic [31:0] inverter_address;
		logic [31:0] controller_address;
		logic [7:0]  option_first;
		logic [7:0]  option_second;
		logic [31:0] unix_time;
	} req_t;

	typedef struct packed {
		logic [7:0]       frame_byte;
		logic [POS_W-1:0] byte_position;
		logic             last_byte;
	} frm_t;

	// Modbus CRC16, LSB first, one byte
	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] v;
		v = acc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (v[0]) begin
				v = (v >> 1) ^ CRC16_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

	// Unreflected CRC8, MSB first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] v;
		v = acc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = (v << 1) ^ CRC8_POLY;
			end else begin
				v = v << 1;
			end
		end
		return v;
	endfunction

endpackage

>>> hdl/time_set_frame_builder_core.sv
// ----------------------------------------------------------------------------
// time_set_frame_builder_core
// Builds a 27-byte time-set radio frame per request and streams it out one
// byte per transaction.
// ----------------------------------------------------------------------------
// Each request transaction (inverter address, controller address, two option
// bytes, Unix time) yields 27 byte transactions in frame order, each with its
// position and a last-byte mark on the trailing CRC8. The output register
// moves one byte per cycle while the byte side does not stall, and a waiting
// request is handed to the serialiser in the same cycle that the previous
// frame's last byte leaves it, so frames follow one another with no gap. On
// an idle block a request passes the input register and the serialiser's
// request register before its first byte reaches the output register. One
// request can wait in the input register while a frame is being sent. The
// Modbus CRC16 (bytes 10 to 23) and CRC8 (bytes 0 to 25) are folded one byte
// per unstalled cycle as bytes go out, so no wide CRC logic sits in any path.
module time_set_frame_builder_core
	import tsfb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic byte_valid,
	input  logic byte_stall,
	output frm_t byte_data
);

	// Input holding register: one request may wait here
	logic in_vld_q;
	req_t in_q;
	logic load_take;

	// Stall only while a request is held and the serialiser cannot take it
	assign req_stall = in_vld_q && !load_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_q <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				in_vld_q <= 1'b1;
			end else if (load_take) begin
				in_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			in_q <= req_data;
		end
	end

	// Serialise the held request and fold the CRCs
	tsfb_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (in_vld_q),
		.load_req   (in_q),
		.load_take  (load_take),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data)
	);

endmodule

>>> hdl/tsfb_byte_sel.sv
// ----------------------------------------------------------------------------
// tsfb_byte_sel
// Selects the frame byte for one position from the request fields and the
// running CRC values.
// ----------------------------------------------------------------------------
module tsfb_byte_sel
	import tsfb_pkg::*;
(
	input  req_t             req,
	input  logic [POS_W-1:0] pos,
	input  logic [15:0]      crc16,
	input  logic [7:0]       crc8,
	output logic [7:0]       frame_byte
);

	always_comb begin
		unique case (pos)
			POS_HDR:      frame_byte = HDR_BYTE;
			POS_INV0:     frame_byte = req.inverter_address[7:0];
			POS_INV1:     frame_byte = req.inverter_address[15:8];
			POS_INV2:     frame_byte = req.inverter_address[23:16];
			POS_INV3:     frame_byte = req.inverter_address[31:24];
			POS_CTL0:     frame_byte = req.controller_address[7:0];
			POS_CTL1:     frame_byte = req.controller_address[15:8];
			POS_CTL2:     frame_byte = req.controller_address[23:16];
			POS_CTL3:     frame_byte = req.controller_address[31:24];
			POS_MARK:     frame_byte = MARK_BYTE;
			POS_OPT0:     frame_byte = req.option_first;
			POS_OPT1:     frame_byte = req.option_second;
			POS_TIME3:    frame_byte = req.unix_time[31:24];
			POS_TIME2:    frame_byte = req.unix_time[23:16];
			POS_TIME1:    frame_byte = req.unix_time[15:8];
			POS_TIME0:    frame_byte = req.unix_time[7:0];
			POS_FIXED:    frame_byte = FIXED_BYTE;
			POS_C16_HI:   frame_byte = crc16[15:8];
			POS_C16_LO:   frame_byte = crc16[7:0];
			POS_C8:       frame_byte = crc8;
			default:      frame_byte = 8'h00;  // padding
		endcase
	end

endmodule

>>> hdl/tsfb_serializer.sv
// ----------------------------------------------------------------------------
// tsfb_serializer
// Walks one request through the 27 frame positions, folds each covered byte
// into its running CRCs and holds the result in the output register.
// ----------------------------------------------------------------------------
module tsfb_serializer
	import tsfb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load_valid,
	input  req_t load_req,
	output logic load_take,
	output logic byte_valid,
	input  logic byte_stall,
	output frm_t byte_data
);

	logic             active_q;
	req_t             req_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      crc16_q;
	logic [7:0]       crc8_q;
	logic             out_vld_q;
	frm_t             out_q;

	logic       adv;
	logic       emit;
	logic       last;
	logic [7:0] cur_byte;
	logic       in_c16;

	tsfb_byte_sel u_byte_sel (
		.req        (req_q),
		.pos        (pos_q),
		.crc16      (crc16_q),
		.crc8       (crc8_q),
		.frame_byte (cur_byte)
	);

	assign adv       = !out_vld_q || !byte_stall;
	assign emit      = adv && active_q;
	assign last      = (pos_q == POS_C8);
	assign in_c16    = (pos_q >= POS_OPT0) && (pos_q <= POS_C16_LAST);
	assign load_take = load_valid && (!active_q || (emit && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			out_vld_q <= 1'b0;
			pos_q     <= '0;
		end else begin
			if (adv) begin
				out_vld_q <= active_q;
			end
			if (load_take) begin
				active_q <= 1'b1;
				pos_q    <= '0;
			end else if (emit) begin
				// drop out of the frame after the CRC8 byte
				active_q <= !last;
				pos_q    <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_take) begin
			req_q   <= load_req;
			crc16_q <= CRC16_INIT;
			crc8_q  <= CRC8_INIT;
		end else if (emit) begin
			if (in_c16) begin
				crc16_q <= crc16_byte(crc16_q, cur_byte);
			end
			if (!last) begin
				crc8_q <= crc8_byte(crc8_q, cur_byte);
			end
		end
		if (emit) begin
			out_q.frame_byte    <= cur_byte;
			out_q.byte_position <= pos_q;
			out_q.last_byte     <= last;
		end
	end

	assign byte_valid = out_vld_q;
	assign byte_data  = out_q;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the time-set frame builder: requests go in through
// the request channel, every frame byte is checked against a frame predicted
// in the bench.
// ----------------------------------------------------------------------------
// A short directed table runs first: field extremes, byte-order patterns and
// alternating bits. Some rows carry one frame byte typed in by hand. Randomised
// requests follow. Both channels idle and stall at random. The run includes a
// stretch with no idling, one long hold-off of the byte channel while
// requests keep coming, and pauses of the request side until every
// outstanding byte has arrived.
// ----------------------------------------------------------------------------
module testbench;
	import tsfb_pkg::*;

	localparam int unsigned IDLE_PCT     = 27;
	localparam int unsigned RANDOM_ITEMS = 205;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SETTLE       = 20;

	// Hand-written row of the directed table; a pinned row also carries one
	// frame byte whose value is evident from the request itself
	typedef struct {
		req_t             stim;
		bit               pinned;
		logic [POS_W-1:0] pin_pos;
		logic [7:0]       pin_byte;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic byte_valid;
	logic byte_stall;
	frm_t byte_data;

	frm_t        pending_bytes[$];
	stim_row_t   stim_table[$];
	int unsigned error_count;
	int unsigned bytes_seen;

	time_set_frame_builder_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Modbus CRC16, fed least significant data bit first
	function automatic logic [15:0] modbus_update(input logic [15:0] acc, input logic [7:0] d);
		logic [15:0] s;
		logic        fb;
		s = acc;
		for (int j = 0; j < 8; j++) begin
			fb = s[0] ^ d[j];
			s  = s >> 1;
			if (fb) begin
				s = s ^ CRC16_POLY;
			end
		end
		return s;
	endfunction

	// Plain CRC8, fed most significant data bit first
	function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] s;
		logic       fb;
		s = acc;
		for (int j = 0; j < 8; j++) begin
			fb = s[7] ^ d[7 - j];
			s  = s << 1;
			if (fb) begin
				s = s ^ CRC8_POLY;
			end
		end
		return s;
	endfunction

	// Lay out the whole frame for one request; byte i sits at bits [8*i +: 8]
	function automatic logic [8*FRAME_LEN-1:0] assemble_time_set_frame(input req_t r);
		logic [7:0]               b [FRAME_LEN];
		logic [8*FRAME_LEN-1:0]   fr;
		logic [15:0]              modbus;
		logic [7:0]               chk8;
		for (int i = 0; i < FRAME_LEN; i++) begin
			b[i] = 8'h00;
		end
		b[POS_HDR]  = HDR_BYTE;
		b[POS_MARK] = MARK_BYTE;
		for (int k = 0; k < 4; k++) begin
			// addresses go low byte first, the time high byte first
			b[int'(POS_INV0) + k]  = r.inverter_address[8*k +: 8];
			b[int'(POS_CTL0) + k]  = r.controller_address[8*k +: 8];
			b[int'(POS_TIME3) + k] = r.unix_time[8*(3-k) +: 8];
		end
		b[POS_OPT0]  = r.option_first;
		b[POS_OPT1]  = r.option_second;
		b[POS_FIXED] = FIXED_BYTE;

		modbus = CRC16_INIT;
		for (int i = int'(POS_OPT0); i <= int'(POS_C16_LAST); i++) begin
			modbus = modbus_update(modbus, b[i]);
		end
		b[POS_C16_HI] = modbus[15:8];
		b[POS_C16_LO] = modbus[7:0];

		chk8 = CRC8_INIT;
		for (int i = 0; i <= int'(POS_C16_LO); i++) begin
			chk8 = crc8_update(chk8, b[i]);
		end
		b[POS_C8] = chk8;

		for (int i = 0; i < FRAME_LEN; i++) begin
			fr[8*i +: 8] = b[i];
		end
		return fr;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [7:0] pick_octet();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom());
		endcase
	endfunction

	task automatic add_row(input logic [31:0] inv, input logic [31:0] ctl,
			input logic [7:0] opt_a, input logic [7:0] opt_b, input logic [31:0] tm,
			input bit pinned, input logic [POS_W-1:0] pos, input logic [7:0] val);
		stim_row_t row;
		row.stim.inverter_address   = inv;
		row.stim.controller_address = ctl;
		row.stim.option_first       = opt_a;
		row.stim.option_second      = opt_b;
		row.stim.unix_time          = tm;
		row.pinned                  = pinned;
		row.pin_pos                 = pos;
		row.pin_byte                = val;
		stim_table.push_back(row);
	endtask

	// Drop valid and hold until every outstanding byte has been taken
	task automatic drain_frames();
		req_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_bytes.size() != 0);
	endtask

	// Offer one request, wait for its transaction, then queue the expected frame
	task automatic offer_request(input req_t r, input bit pinned,
			input logic [POS_W-1:0] pin_pos, input logic [7:0] pin_byte, input bit calm);
		logic [8*FRAME_LEN-1:0] fr;
		logic [127:0]           junk;
		frm_t                   want;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			junk = {$urandom(), $urandom(), $urandom(), $urandom()};
			req_valid <= 1'b0;
			req_data  <= junk[$bits(req_t)-1:0];
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do begin
			@(posedge clk);
		end while (req_stall !== 1'b0);

		fr = assemble_time_set_frame(r);
		if (pinned) begin
			// the hand-typed byte overrides the prediction for this position
			fr[8*pin_pos +: 8] = pin_byte;
		end
		for (int i = 0; i < FRAME_LEN; i++) begin
			want.frame_byte    = fr[8*i +: 8];
			want.byte_position = POS_W'(i);
			want.last_byte     = (i == FRAME_LEN - 1);
			pending_bytes.push_back(want);
		end
	endtask

	// Request side: reset, directed table, then randomised requests
	initial begin : request_source
		req_t r;
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req_data    <= '0;
		error_count = 0;

		add_row(32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 32'h0000_0000, 1'b1, POS_HDR, 8'h15);
		add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, POS_INV0, 8'hFF);
		add_row(32'h0102_0304, 32'h0000_0000, 8'h00, 8'h00, 32'h0000_0000, 1'b1, POS_INV0, 8'h04);
		add_row(32'h0102_0304, 32'h0000_0000, 8'h00, 8'h00, 32'h0000_0000, 1'b1, POS_INV3, 8'h01);
		add_row(32'h0000_0000, 32'hA1B2_C3D4, 8'h00, 8'h00, 32'h0000_0000, 1'b1, POS_CTL0, 8'hD4);
		add_row(32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 8'h00, 32'h0000_0000, 1'b1, POS_CTL3, 8'hFF);
		add_row(32'h0000_0000, 32'h0000_0000, 8'hFF, 8'h00, 32'h0000_0000, 1'b1, POS_OPT0, 8'hFF);
		add_row(32'h0000_0000, 32'h0000_0000, 8'h00, 8'hFF, 32'h0000_0000, 1'b1, POS_OPT1, 8'hFF);
		add_row(32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 32'h8000_0000, 1'b1, POS_TIME3, 8'h80);
		add_row(32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 32'h0000_00FF, 1'b1, POS_TIME0, 8'hFF);
		add_row(32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1, POS_FIXED, 8'h05);
		add_row(32'hAAAA_AAAA, 32'h5555_5555, 8'hAA, 8'h55, 32'hAAAA_AAAA, 1'b1, POS_MARK, 8'h80);
		add_row(32'h5555_5555, 32'hAAAA_AAAA, 8'h55, 8'hAA, 32'h5555_5555, 1'b0, POS_HDR, 8'h00);
		add_row(32'h0000_0001, 32'h8000_0000, 8'h01, 8'h80, 32'h7FFF_FFFF, 1'b0, POS_HDR, 8'h00);
		add_row(32'h1122_3344, 32'h5566_7788, 8'h00, 8'h00, 32'h65A0_BC00, 1'b0, POS_HDR, 8'h00);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[i]) begin
			offer_request(stim_table[i].stim, stim_table[i].pinned,
				stim_table[i].pin_pos, stim_table[i].pin_byte, 1'b0);
		end
		// let the directed frames run out before the random part
		drain_frames();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 140) begin
				drain_frames();
			end
			r.inverter_address   = pick_word();
			r.controller_address = pick_word();
			r.option_first       = pick_octet();
			r.option_second      = pick_octet();
			r.unix_time          = pick_word();
			// offer back to back for a stretch, no idle cycles at all
			offer_request(r, 1'b0, POS_HDR, 8'h00, (n >= 60 && n < 110));
		end

		drain_frames();
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Byte side: check every byte transaction and drive the stall
	initial begin : byte_sink
		frm_t        want;
		int unsigned hold_left;
		bit          long_hold_done;
		hold_left      = 0;
		long_hold_done = 1'b0;
		bytes_seen     = 0;
		byte_stall     <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && byte_valid === 1'b1 && byte_stall === 1'b0) begin
				bytes_seen++;
				if (pending_bytes.size() == 0) begin
					$error("byte transaction with nothing expected: %p", byte_data);
					error_count++;
				end else begin
					want = pending_bytes.pop_front();
					if (byte_data.frame_byte !== want.frame_byte) begin
						$error("frame_byte: expected %02h, got %02h",
							want.frame_byte, byte_data.frame_byte);
						error_count++;
					end
					if (byte_data.byte_position !== want.byte_position) begin
						$error("byte_position: expected %0d, got %0d",
							want.byte_position, byte_data.byte_position);
						error_count++;
					end
					if (byte_data.last_byte !== want.last_byte) begin
						$error("last_byte: expected %0b, got %0b",
							want.last_byte, byte_data.last_byte);
						error_count++;
					end
				end
			end

			// hold off for a long while once, so the request side backs up
			if (!long_hold_done && bytes_seen >= 1500) begin
				long_hold_done = 1'b1;
				hold_left      = 240;
			end
			if (hold_left != 0) begin
				hold_left--;
				byte_stall <= 1'b1;
			end else if (bytes_seen >= 2500 && bytes_seen < 3800) begin
				byte_stall <= 1'b0;
			end else begin
				byte_stall <= ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Stop a hung run
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
hdl/tsfb_pkg.sv
hdl/tsfb_byte_sel.sv
hdl/tsfb_serializer.sv
hdl/time_set_frame_builder_core.sv
test/testbench.sv
